/* rtl/core/lfu_pkg.sv */
// Shared types and constants for the LFU cache table.
package lfu_pkg;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_PICK   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_OUT    = 5'b10000
  } lfu_state_e;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;
  localparam int unsigned CAP_BITS = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the input item
    logic search;  // register match / victim results
    logic update;  // commit state change and result
  } lfu_cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic dummy_ok;
  } lfu_sts_t;

endpackage

/* rtl/core/lfu_cache_table.sv */
// Top level of the LFU cache table.
// Usage:
//   Input channel in_valid_i/in_ready_o carries mode_i (0 get, 1 put),
//   lookup_key_i and write_value_i. Output channel out_valid_o/out_ready_i
//   carries hit_o, read_value_o, evicted_o and evicted_key_o, one result
//   item per input item, in order.
//   An accepted item passes the search, pick, update and output states
//   before out_valid_o rises; the controller then returns to idle, and
//   only there is the next item taken, so items never overlap in the
//   all-slot match and LFU/LRU victim search.
//   The result register holds while the receiver stalls; a new item is
//   accepted only when no result waits or the waiting one is taken in
//   the same cycle, so no result is overwritten.
//   capacity_we_i/capacity_i write the capacity register at once; write
//   only while idle. Reset empties all slots and sets capacity to 16.
module lfu_cache_table import lfu_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         capacity_we_i,
  input  logic [CAP_BITS-1:0]          capacity_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [KEY_BITS-1:0]          lookup_key_i,
  input  logic signed [VALUE_BITS-1:0] write_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic                         evicted_o,
  output logic [KEY_BITS-1:0]          evicted_key_o
);

  logic [CAP_BITS-1:0] cap_q;
  lfu_cmd_t cmd;
  lfu_sts_t sts;

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CAP_BITS'(16);
    else if (capacity_we_i) cap_q <= capacity_i;
  end

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lfu_dpath #(
    .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS),
    .VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cap_i(cap_q),
    .mode_i, .lookup_key_i, .write_value_i,
    .hit_o, .read_value_o, .evicted_o, .evicted_key_o
  );

endmodule

/* rtl/core/lfu_ctrl.sv */
// Controller state machine for the LFU cache table.
module lfu_ctrl import lfu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  lfu_sts_t sts_i,
  output lfu_cmd_t cmd_o
);

  lfu_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // In idle, accept a new item while the output register is empty or draining
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = ST_PICK;
      end
      ST_PICK: begin
        state_d = sts_i.dummy_ok ? ST_UPDATE : ST_PICK;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/lfu_dpath.sv */
// Datapath for the LFU cache table: slot storage, match, victim search, update.
module lfu_dpath import lfu_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lfu_cmd_t                     cmd_i,
  output lfu_sts_t                     sts_o,
  input  logic [CAP_BITS-1:0]          cap_i,
  input  logic                         mode_i,
  input  logic [KEY_BITS-1:0]          lookup_key_i,
  input  logic signed [VALUE_BITS-1:0] write_value_i,
  output logic                         hit_o,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic                         evicted_o,
  output logic [KEY_BITS-1:0]          evicted_key_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [ENTRIES-1:0]   valid_q;
  logic [KEY_BITS-1:0]  key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] val_q  [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_q  [ENTRIES];
  logic [IW-1:0]        rank_q  [ENTRIES];

  logic                  mode_q;
  logic [KEY_BITS-1:0]   key_in_q;
  logic [VALUE_BITS-1:0] val_in_q;

  // Match vector, computed per slot
  logic [ENTRIES-1:0] match_v;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) match_v[i] = valid_q[i] && (key_q[i] == key_in_q);
  end

  // Victim search, combinational: lowest count, ties to the highest rank;
  // compare each slot against all others (independent per slot)
  logic [ENTRIES-1:0] vic_v;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      vic_v[i] = valid_q[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (j != i && valid_q[j] && (cnt_q[j] < cnt_q[i] ||
            (cnt_q[j] == cnt_q[i] && rank_q[j] > rank_q[i])))
          vic_v[i] = 1'b0;
      end
    end
  end

  // Search stage registers
  logic               found_q;
  logic [IW-1:0]      found_idx_q;
  logic               vic_ok_q;
  logic [IW-1:0]      vic_idx_q;
  logic               free_ok_q;
  logic [IW-1:0]      free_idx_q;
  logic [NW-1:0]      used_q;

  logic               found_d, vic_ok_d, free_ok_d;
  logic [IW-1:0]      found_idx_d, vic_idx_d, free_idx_d;
  logic [NW-1:0]      used_d;
  always_comb begin
    found_d = 1'b0; found_idx_d = '0;
    vic_ok_d = 1'b0; vic_idx_d = '0;
    free_ok_d = 1'b0; free_idx_d = '0;
    used_d = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_v[i]) begin found_d = 1'b1; found_idx_d = IW'(i); end
      if (vic_v[i])   begin vic_ok_d = 1'b1; vic_idx_d = IW'(i); end
      if (!valid_q[i]) begin free_ok_d = 1'b1; free_idx_d = IW'(i); end
    end
    for (int i = 0; i < ENTRIES; i++) used_d = used_d + NW'(valid_q[i]);
  end

  assign sts_o.dummy_ok = 1'b1;

  // Effective capacity, clamped to the table size
  logic [NW:0] cap_eff;
  assign cap_eff = (int'(cap_i) > int'(ENTRIES)) ? (NW+1)'(ENTRIES)
                   : (NW+1)'(cap_i);

  logic do_evict, do_ins, cap_zero;
  logic [IW-1:0] ins_idx;
  assign cap_zero = (cap_eff == '0);
  assign do_evict = (mode_q == MODE_PUT) && !cap_zero && !found_q &&
                    ((NW+1)'(used_q) >= cap_eff) && vic_ok_q;
  assign do_ins   = (mode_q == MODE_PUT) && !cap_zero && !found_q &&
                    (do_evict || free_ok_q);
  assign ins_idx  = do_evict ? vic_idx_q : free_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.update && do_ins) begin
      valid_q[ins_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      key_in_q <= lookup_key_i;
      val_in_q <= write_value_i;
    end
    if (cmd_i.search) begin
      found_q <= found_d; found_idx_q <= found_idx_d;
      vic_ok_q <= vic_ok_d; vic_idx_q <= vic_idx_d;
      free_ok_q <= free_ok_d; free_idx_q <= free_idx_d;
      used_q <= used_d;
    end
    if (cmd_i.update) begin
      // Result
      hit_o         <= found_q && !(mode_q == MODE_PUT && cap_zero);
      read_value_o  <= (found_q && mode_q == MODE_GET) ? val_q[found_idx_q] : '0;
      evicted_o     <= do_evict;
      evicted_key_o <= do_evict ? key_q[vic_idx_q] : '0;
      // Ranks: age entries more recent than the touched/evicted one (all on an insert into a free slot)
      for (int i = 0; i < ENTRIES; i++) begin
        if (found_q && !(mode_q == MODE_PUT && cap_zero)) begin
          if (valid_q[i] && IW'(i) != found_idx_q && rank_q[i] < rank_q[found_idx_q])
            rank_q[i] <= rank_q[i] + 1'b1;
        end else if (do_ins) begin
          if (valid_q[i] && IW'(i) != ins_idx) begin
            if (!do_evict || rank_q[i] < rank_q[vic_idx_q])
              rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end
      if (found_q && !(mode_q == MODE_PUT && cap_zero)) begin
        rank_q[found_idx_q] <= '0;
        if (cnt_q[found_idx_q] != CNT_MAX) cnt_q[found_idx_q] <= cnt_q[found_idx_q] + 1'b1;
        if (mode_q == MODE_PUT) val_q[found_idx_q] <= val_in_q;
      end else if (do_ins) begin
        rank_q[ins_idx] <= '0;
        cnt_q[ins_idx]  <= COUNT_BITS'(1);
        key_q[ins_idx]  <= key_in_q;
        val_q[ins_idx]  <= val_in_q;
      end
    end
  end

endmodule

/* rtl/core/lfu_checker.sv */
// Port-level checker for the LFU cache table, bound to the top level.
module lfu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic hit_o,
  input logic evicted_o
);

  // A stalled result stays valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

  // No eviction together with a hit
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o)) else $error("hit and evict");

  // Acceptance is followed by a busy cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready while busy");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .hit_o, .evicted_o
);
